// ===== src/tcq_pkg.sv =====
// shared constants, codes and state types for the touch contact qualifier
`timescale 1ns / 1ps

package tcq_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DISP_BITS      = 13;
  localparam int HOLD_BITS      = 14;
  localparam int POINT_BITS     = 16;
  localparam int CFG_IDX_BITS   = 3;

  localparam int TAP_MAX_POLLS  = 5;
  localparam int RUN_WRAP       = 10000;
  localparam int POINT_MAX      = 2 ** (POINT_BITS - 1) - 1;
  localparam int POINT_MIN_MAG  = 2 ** (POINT_BITS - 1);

  localparam int SRC_X_A_RST    = 800;
  localparam int SRC_X_B_RST    = 0;
  localparam int SRC_Y_A_RST    = 480;
  localparam int SRC_Y_B_RST    = 0;
  localparam int DISP_W_RST     = 800;
  localparam int DISP_H_RST     = 480;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_FAIL     = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FILTER_ENABLE = 3'd0,
    REG_SWAP_AXES     = 3'd1,
    REG_SRC_X_A       = 3'd2,
    REG_SRC_X_B       = 3'd3,
    REG_SRC_Y_A       = 3'd4,
    REG_SRC_Y_B       = 3'd5,
    REG_DISP_WIDTH    = 3'd6,
    REG_DISP_HEIGHT   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_EMIT
  } qual_state_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_MUL,
    MS_DIV
  } map_state_t;

endpackage

// ===== src/touch_contact_qualifier.sv =====
// top level: poll qualification, wake handling, two-axis mapping and result register
`timescale 1ns / 1ps

//  channel   | handshake              | beat contents
//  ----------+------------------------+------------------------------------------------
//  poll in   | in_valid / in_ready    | contact, raw_x, raw_y, display_asleep
//  event out | out_valid / out_ready  | event_res, point_x, point_y, wake_request
//  config    | cfg_wr_en (no stall)   | cfg_index, cfg_data
//
//  a mapped tap runs the map unit on each axis in turn: a serial multiply, a serial divide
//  and a saturation, with registered handover between them; a zero source range skips the
//  multiply and divide for that axis and maps it to 0; any other poll goes straight to the
//  result register; one poll is in flight at a time
//  the result register lets the next poll be taken while a beat waits on out_ready
//  rst is synchronous; it restores the register defaults and clears all run state

module touch_contact_qualifier import tcq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration writes
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [((COORD_BITS > DISP_BITS) ? COORD_BITS : DISP_BITS)-1:0] cfg_data,
  // poll samples
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         contact,
  input  logic [COORD_BITS-1:0]        raw_x,
  input  logic [COORD_BITS-1:0]        raw_y,
  input  logic                         display_asleep,
  // qualified events
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   event_res,
  output logic signed [POINT_BITS-1:0] point_x,
  output logic signed [POINT_BITS-1:0] point_y,
  output logic                         wake_request
);

  localparam int CMP_W = COORD_BITS + POINT_BITS;

  // configuration registers
  logic                         filter_enable;
  logic                         swap_axes;
  logic [COORD_BITS-1:0]        src_x_a;
  logic [COORD_BITS-1:0]        src_x_b;
  logic [COORD_BITS-1:0]        src_y_a;
  logic [COORD_BITS-1:0]        src_y_b;
  logic [DISP_BITS-1:0]         disp_width;
  logic [DISP_BITS-1:0]         disp_height;

  // contact run state
  logic [HOLD_BITS-1:0]         hold_count;
  logic                         held_before;
  logic [COORD_BITS-1:0]        kept_x;
  logic [COORD_BITS-1:0]        kept_y;
  logic                         pressed_latched;
  logic                         wake_pending;
  logic                         wake_released;

  logic [HOLD_BITS-1:0]         hold_count_next;
  logic [HOLD_BITS-1:0]         hold_base;
  logic                         held_before_next;
  logic [COORD_BITS-1:0]        kept_x_next;
  logic [COORD_BITS-1:0]        kept_y_next;
  logic                         pressed_latched_next;
  logic                         wake_pending_next;
  logic                         wake_released_next;
  logic                         tap;
  event_t                       ev_next;
  logic                         wake_next;
  logic                         map_next;

  // poll in flight
  qual_state_t                  state;
  qual_state_t                  state_next;
  logic                         need_map;
  event_t                       res_ev;
  logic                         res_wake;
  logic [COORD_BITS-1:0]        ux;
  logic [COORD_BITS-1:0]        uy;
  logic signed [POINT_BITS-1:0] mx;
  logic signed [POINT_BITS-1:0] my;

  // map unit hookup
  logic                         map_go;
  logic                         map_start;
  logic                         map_done;
  logic signed [POINT_BITS-1:0] map_res;
  logic [COORD_BITS-1:0]        map_v;
  logic [COORD_BITS-1:0]        map_a;
  logic [COORD_BITS-1:0]        map_b;
  logic [DISP_BITS-1:0]         map_d;

  // result beat
  logic                         accept;
  logic                         load;
  logic                         in_x;
  logic                         in_y;
  event_t                       ev_emit;
  logic [POINT_BITS-1:0]        px_emit;
  logic [POINT_BITS-1:0]        py_emit;

  assign accept = in_valid && in_ready;

  // configuration port, taken whenever the enable is high
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      swap_axes     <= 1'b0;
      src_x_a       <= COORD_BITS'(SRC_X_A_RST);
      src_x_b       <= COORD_BITS'(SRC_X_B_RST);
      src_y_a       <= COORD_BITS'(SRC_Y_A_RST);
      src_y_b       <= COORD_BITS'(SRC_Y_B_RST);
      disp_width    <= DISP_BITS'(DISP_W_RST);
      disp_height   <= DISP_BITS'(DISP_H_RST);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_SWAP_AXES:     swap_axes     <= cfg_data[0];
        REG_SRC_X_A:       src_x_a       <= cfg_data[COORD_BITS-1:0];
        REG_SRC_X_B:       src_x_b       <= cfg_data[COORD_BITS-1:0];
        REG_SRC_Y_A:       src_y_a       <= cfg_data[COORD_BITS-1:0];
        REG_SRC_Y_B:       src_y_b       <= cfg_data[COORD_BITS-1:0];
        REG_DISP_WIDTH:    disp_width    <= cfg_data[DISP_BITS-1:0];
        REG_DISP_HEIGHT:   disp_height   <= cfg_data[DISP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // poll qualification: what the run state becomes if this beat is taken
  assign hold_base = (hold_count > HOLD_BITS'(RUN_WRAP)) ? '0 : hold_count;

  always_comb begin
    hold_count_next      = hold_count;
    held_before_next     = held_before;
    kept_x_next          = kept_x;
    kept_y_next          = kept_y;
    pressed_latched_next = pressed_latched;
    wake_pending_next    = wake_pending;
    wake_released_next   = wake_released;
    tap                  = 1'b0;
    ev_next              = EV_NONE;
    wake_next            = 1'b0;
    map_next             = 1'b0;

    if (filter_enable) begin
      if (contact) begin
        // long runs wrap so the counter never overflows
        hold_count_next  = hold_base + HOLD_BITS'(1);
        kept_x_next      = raw_x;
        kept_y_next      = raw_y;
        held_before_next = 1'b1;
      end else begin
        // short contact that just ended counts as a tap
        if (hold_count <= HOLD_BITS'(TAP_MAX_POLLS) && held_before) begin
          pressed_latched_next = 1'b1;
          tap                  = 1'b1;
        end
        hold_count_next  = '0;
        held_before_next = 1'b0;
      end
    end else if (contact) begin
      kept_x_next          = raw_x;
      kept_y_next          = raw_y;
      pressed_latched_next = 1'b1;
      tap                  = 1'b1;
    end

    if (tap) begin
      if (display_asleep) begin
        wake_pending_next  = 1'b1;
        wake_released_next = 1'b0;
        wake_next          = 1'b1;
      end else if (!(wake_pending && !wake_released)) begin
        map_next = 1'b1;
      end
    end else if (!contact && pressed_latched) begin
      pressed_latched_next = 1'b0;
      ev_next              = EV_RELEASED;
      wake_released_next   = 1'b1;
      wake_pending_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count      <= '0;
      held_before     <= 1'b0;
      kept_x          <= '0;
      kept_y          <= '0;
      pressed_latched <= 1'b0;
      wake_pending    <= 1'b0;
      wake_released   <= 1'b0;
    end else if (accept) begin
      hold_count      <= hold_count_next;
      held_before     <= held_before_next;
      kept_x          <= kept_x_next;
      kept_y          <= kept_y_next;
      pressed_latched <= pressed_latched_next;
      wake_pending    <= wake_pending_next;
      wake_released   <= wake_released_next;
    end
  end

  // per-poll payload, held until the beat is emitted
  always_ff @(posedge clk) begin
    if (accept) begin
      need_map <= map_next;
      res_ev   <= ev_next;
      res_wake <= wake_next;
      ux       <= swap_axes ? kept_y_next : kept_x_next;
      uy       <= swap_axes ? kept_x_next : kept_y_next;
    end
    if (state == ST_MAP_X && map_done) begin
      mx <= map_res;
    end
    if (state == ST_MAP_Y && map_done) begin
      my <= map_res;
    end
  end

  // one map unit shared between the axes
  always_comb begin
    if (state == ST_MAP_X) begin
      map_v = ux;
      map_a = src_x_a;
      map_b = src_x_b;
      map_d = disp_width;
    end else begin
      map_v = uy;
      map_a = src_y_a;
      map_b = src_y_b;
      map_d = disp_height;
    end
  end

  tcq_map #(
    .COORD_BITS (COORD_BITS)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .start (map_start),
    .v     (map_v),
    .a     (map_a),
    .b     (map_b),
    .d     (map_d),
    .done  (map_done),
    .res   (map_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      map_start <= 1'b0;
    end else begin
      state     <= state_next;
      map_start <= map_go;
    end
  end

  always_comb begin
    state_next = state;
    map_go     = 1'b0;
    load       = 1'b0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = map_next ? ST_MAP_X : ST_EMIT;
          map_go     = map_next;
        end
      end
      ST_MAP_X: begin
        if (map_done) begin
          state_next = ST_MAP_Y;
          map_go     = 1'b1;
        end
      end
      ST_MAP_Y: begin
        if (map_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // bounds check against the mapping origins
  assign in_x = !mx[POINT_BITS-1] && (CMP_W'(mx[POINT_BITS-2:0]) < CMP_W'(src_x_a));
  assign in_y = !my[POINT_BITS-1] && (CMP_W'(my[POINT_BITS-2:0]) < CMP_W'(src_y_a));

  always_comb begin
    if (need_map) begin
      ev_emit = (in_x && in_y) ? EV_PRESSED : EV_FAIL;
      px_emit = mx;
      py_emit = my;
    end else begin
      ev_emit = res_ev;
      px_emit = '0;
      py_emit = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_res    <= ev_emit;
      point_x      <= $signed(px_emit);
      point_y      <= $signed(py_emit);
      wake_request <= res_wake;
    end
  end

endmodule

// ===== src/tcq_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module tcq_mul import tcq_pkg::*; #(
  parameter int A_W = COORD_BITS_DEF,
  parameter int B_W = DISP_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     mcand,
  input  logic [B_W-1:0]     mplier,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   mc;
  logic [P_W-1:0]   acc;
  logic [A_W:0]     sum;

  // upper half plus multiplicand when the current multiplier bit is set
  assign sum = {1'b0, acc[P_W-1:B_W]} + (acc[0] ? {1'b0, mc} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= mcand;
      acc <= {{A_W{1'b0}}, mplier};
    end else if (busy) begin
      acc <= {sum, acc[B_W-1:1]};
    end
  end

  assign product = acc;

endmodule

// ===== src/tcq_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tcq_div import tcq_pkg::*; #(
  parameter int N_W = COORD_BITS_DEF + DISP_BITS,
  parameter int D_W = COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dv;
  logic [N_W-1:0]   quo;
  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             ge;

  assign shifted = {rem, quo[N_W-1]};
  assign trial   = shifted - {1'b0, dv};
  assign ge      = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
      quo <= {quo[N_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== src/tcq_map.sv =====
// one-axis linear mapping: sign split, serial multiply, serial divide, saturation
`timescale 1ns / 1ps

module tcq_map import tcq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [COORD_BITS-1:0]        v,
  input  logic [COORD_BITS-1:0]        a,
  input  logic [COORD_BITS-1:0]        b,
  input  logic [DISP_BITS-1:0]         d,
  output logic                         done,
  output logic signed [POINT_BITS-1:0] res
);

  localparam int PROD_W = COORD_BITS + DISP_BITS;

  map_state_t                state;
  map_state_t                state_next;

  logic [COORD_BITS:0]       diff_va;
  logic [COORD_BITS:0]       diff_ba;
  logic [COORD_BITS:0]       neg_va;
  logic [COORD_BITS:0]       neg_ba;
  logic [COORD_BITS-1:0]     va_mag;
  logic [COORD_BITS-1:0]     ba_mag;
  logic [DISP_BITS-1:0]      dm1_mag;
  logic                      d_zero;

  logic                      neg;
  logic [COORD_BITS-1:0]     span_mag;

  logic                      mul_go;
  logic                      mul_done;
  logic [PROD_W-1:0]         prod;
  logic                      div_go;
  logic                      div_done;
  logic [PROD_W-1:0]         quo;

  logic                      fin;
  logic [POINT_BITS-1:0]     res_next;
  logic [POINT_BITS-1:0]     sat;
  logic [POINT_BITS-1:0]     quo_low;

  // magnitudes and signs of (v - a), (d - 1) and (b - a)
  assign diff_va = {1'b0, v} - {1'b0, a};
  assign diff_ba = {1'b0, b} - {1'b0, a};
  assign neg_va  = -diff_va;
  assign neg_ba  = -diff_ba;
  assign va_mag  = diff_va[COORD_BITS] ? neg_va[COORD_BITS-1:0] : diff_va[COORD_BITS-1:0];
  assign ba_mag  = diff_ba[COORD_BITS] ? neg_ba[COORD_BITS-1:0] : diff_ba[COORD_BITS-1:0];
  assign d_zero  = (d == '0);
  assign dm1_mag = d_zero ? DISP_BITS'(1) : d - 1'b1;

  tcq_mul #(
    .A_W (COORD_BITS),
    .B_W (DISP_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_go),
    .mcand   (va_mag),
    .mplier  (dm1_mag),
    .done    (mul_done),
    .product (prod)
  );

  tcq_div #(
    .N_W (PROD_W),
    .D_W (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (prod),
    .divisor  (span_mag),
    .done     (div_done),
    .quotient (quo)
  );

  // saturate the signed quotient to the point range
  assign quo_low = quo[POINT_BITS-1:0];
  always_comb begin
    if (neg) begin
      sat = (quo > PROD_W'(POINT_MIN_MAG)) ? POINT_BITS'(POINT_MIN_MAG) : -quo_low;
    end else begin
      sat = (quo > PROD_W'(POINT_MAX)) ? POINT_BITS'(POINT_MAX) : quo_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == MS_IDLE && start) begin
      neg      <= diff_va[COORD_BITS] ^ d_zero ^ diff_ba[COORD_BITS];
      span_mag <= ba_mag;
    end
    if (fin) begin
      res <= $signed(res_next);
    end
  end

  always_comb begin
    state_next = state;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    fin        = 1'b0;
    res_next   = sat;
    case (state)
      MS_IDLE: begin
        if (start) begin
          if (ba_mag == '0) begin
            // zero source range maps to 0
            fin      = 1'b1;
            res_next = '0;
          end else begin
            mul_go     = 1'b1;
            state_next = MS_MUL;
          end
        end
      end
      MS_MUL: begin
        if (mul_done) begin
          div_go     = 1'b1;
          state_next = MS_DIV;
        end
      end
      MS_DIV: begin
        if (div_done) begin
          fin        = 1'b1;
          state_next = MS_IDLE;
        end
      end
      default: begin
        state_next = MS_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tcq_checker.sv =====
// port-level checker for the touch contact qualifier, bound to the top level
`timescale 1ns / 1ps

module tcq_checker import tcq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_wr_en,
  input logic [CFG_IDX_BITS-1:0]      cfg_index,
  input logic [((COORD_BITS > DISP_BITS) ? COORD_BITS : DISP_BITS)-1:0] cfg_data,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         contact,
  input logic [COORD_BITS-1:0]        raw_x,
  input logic [COORD_BITS-1:0]        raw_y,
  input logic                         display_asleep,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   event_res,
  input logic signed [POINT_BITS-1:0] point_x,
  input logic signed [POINT_BITS-1:0] point_y,
  input logic                         wake_request
);

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(point_x)
      && $stable(point_y) && $stable(wake_request))
    else $error("output beat changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result still valid after reset");

  // a press lies inside the mapped window
  a_press_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_PRESSED |-> !point_x[POINT_BITS-1] && !point_y[POINT_BITS-1])
    else $error("pressed beat with a negative point");

  // no point is reported with none or release
  a_no_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_NONE || event_res == EV_RELEASED)
      |-> point_x == '0 && point_y == '0)
    else $error("point reported without press or failure");

  // a wake touch carries no event
  a_wake_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_request |-> event_res == EV_NONE)
    else $error("wake request together with an event");

endmodule

bind touch_contact_qualifier tcq_checker #(.COORD_BITS(COORD_BITS)) u_tcq_checker (.*);
